FILE: rtl/wtld_pkg.sv
`default_nettype none
package wtld_pkg;

  // Operation codes on the input channel
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_PARENT  = 2'd1;
  localparam logic [1:0] ST_NO_NODE    = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  localparam int DIST_W = 48;
  localparam int OUT_W  = 49;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] node_a;
    logic [15:0] node_b;
    logic [31:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] distance;
    logic [1:0]       status;
  } out_item_t;

  // Command class decided by the front end
  typedef enum logic [1:0] {
    CMD_START,
    CMD_ADD,
    CMD_QUERY,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] node_a;
    logic [15:0] node_b;
    logic [31:0] weight;
  } cmd_item_t;

endpackage
`default_nettype wire

FILE: rtl/wtld_front.sv
`default_nettype none
module wtld_front import wtld_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           cmd_valid,
  input  wire logic      cmd_pop,
  output cmd_item_t      cmd_head
);

  cmd_item_t  q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_item_t  cls;

  // Classify the opcode
  always_comb begin
    unique case (in_data.operation)
      OP_START: cls.cmd = CMD_START;
      OP_ADD:   cls.cmd = CMD_ADD;
      OP_QUERY: cls.cmd = CMD_QUERY;
      default:  cls.cmd = CMD_NOP;
    endcase
    cls.node_a = in_data.node_a;
    cls.node_b = in_data.node_b;
    cls.weight = in_data.weight;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_head  = q_mem_r[rd_ptr_r];

  // Two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wtld_back.sv
`default_nettype none
module wtld_back import wtld_pkg::*; #(
  parameter int MAX_NODES   = 65536,
  parameter int LIFT_LEVELS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cmd_valid,
  output logic           cmd_pop,
  input  wire cmd_item_t cmd_head,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int NW        = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CW        = $clog2(MAX_NODES + 1);
  localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int AW        = NW + LW;
  localparam int ANC_DEPTH = MAX_NODES * (2 ** LW);

  localparam logic [LW-1:0] LAST_LV = LW'(LIFT_LEVELS - 1);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ADD_PAR, S_ADD_BASE, S_ADD_RD, S_ADD_WR,
    S_Q_RD, S_Q_DEP, S_LIFT_RD, S_LIFT_WR, S_CMP, S_DESC_RD, S_DESC_EV,
    S_FIN_RD, S_FIN_EV, S_DIST_RD, S_DIST_EV, S_DIST_SUM, S_DONE
  } state_t;

  state_t state_r;

  // Per-node stores
  logic [NW-1:0]     dep_mem [MAX_NODES];
  logic [DIST_W-1:0] rd_mem  [MAX_NODES];
  logic [NW-1:0]     anc_mem [ANC_DEPTH];

  logic [NW-1:0]     dep_qa_r, dep_qb_r;
  logic [DIST_W-1:0] rd_qa_r, rd_qb_r;
  logic [NW-1:0]     anc_qa_r, anc_qb_r;

  // Work registers
  logic [CW-1:0]     count_r;
  logic              from_start_r;
  logic [NW-1:0]     a_r, b_r, x_r, y_r;
  logic [31:0]       w_r;
  logic [NW-1:0]     diff_r;
  logic [LW-1:0]     lv_r;
  logic [DIST_W-1:0] ra_r, rb_r, sa_r, sb_r;
  logic [OUT_W-1:0]  dist_r;
  logic [1:0]        status_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [NW-1:0]     new_node;
  logic              head_a_bad, head_b_bad;

  logic              mem_we;
  logic [NW-1:0]     mem_wa;
  logic [NW-1:0]     dep_wd;
  logic [DIST_W-1:0] rd_wd;
  logic              anc_we;
  logic [AW-1:0]     anc_wa;
  logic [NW-1:0]     anc_wd;
  logic [NW-1:0]     rd_ra;

  assign new_node   = count_r[NW-1:0];
  assign head_a_bad = (32'(cmd_head.node_a) >= 32'(count_r));
  assign head_b_bad = (32'(cmd_head.node_b) >= 32'(count_r));
  assign cmd_pop    = (state_r == S_IDLE) && cmd_valid;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // Write port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    dep_wd = '0;
    rd_wd  = '0;
    anc_we = 1'b0;
    anc_wa = '0;
    anc_wd = '0;
    case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        anc_we = 1'b1;
        anc_wa = {NW'(0), lv_r};
      end
      S_ADD_BASE: begin
        mem_we = 1'b1;
        mem_wa = new_node;
        dep_wd = dep_qb_r + NW'(1);
        rd_wd  = rd_qb_r + DIST_W'(w_r);
        anc_we = 1'b1;
        anc_wa = {new_node, LW'(0)};
        anc_wd = b_r;
      end
      S_ADD_WR: begin
        anc_we = 1'b1;
        anc_wa = {new_node, lv_r + LW'(1)};
        anc_wd = anc_qa_r;
      end
      default: ;
    endcase
    rd_ra = (state_r == S_DIST_RD) ? x_r : a_r;
  end

  // Memories: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dep_mem[mem_wa] <= dep_wd;
      rd_mem[mem_wa]  <= rd_wd;
    end
    if (anc_we) begin
      anc_mem[anc_wa] <= anc_wd;
    end
    dep_qa_r <= dep_mem[a_r];
    dep_qb_r <= dep_mem[b_r];
    rd_qa_r  <= rd_mem[rd_ra];
    rd_qb_r  <= rd_mem[b_r];
    anc_qa_r <= anc_mem[{x_r, lv_r}];
    anc_qb_r <= anc_mem[{y_r, lv_r}];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      lv_r         <= '0;
      count_r      <= CW'(1);
      from_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // S_DONE handles the output register itself
      if (out_valid_r && out_ready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        // Write the root entries
        S_INIT: begin
          if (lv_r == LAST_LV) begin
            count_r <= CW'(1);
            lv_r    <= '0;
            state_r <= from_start_r ? S_DONE : S_IDLE;
          end else begin
            lv_r <= lv_r + LW'(1);
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            a_r          <= NW'(cmd_head.node_a);
            b_r          <= NW'(cmd_head.node_b);
            w_r          <= cmd_head.weight;
            dist_r       <= '0;
            lv_r         <= '0;
            unique case (cmd_head.cmd)
              CMD_START: begin
                status_r     <= ST_OK;
                from_start_r <= 1'b1;
                state_r      <= S_INIT;
              end
              CMD_ADD: begin
                if (count_r == CW'(MAX_NODES)) begin
                  status_r <= ST_TABLE_FULL;
                  state_r  <= S_DONE;
                end else if (head_b_bad) begin
                  status_r <= ST_NO_PARENT;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_ADD_PAR;
                end
              end
              CMD_QUERY: begin
                if (head_a_bad || head_b_bad) begin
                  status_r <= ST_NO_NODE;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_Q_RD;
                end
              end
              default: begin
                status_r <= ST_OK;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        // Add: parent depth and distance read
        S_ADD_PAR: state_r <= S_ADD_BASE;
        S_ADD_BASE: begin
          x_r  <= b_r;
          lv_r <= '0;
          if (LAST_LV == LW'(0)) begin
            count_r <= count_r + CW'(1);
            state_r <= S_DONE;
          end else begin
            state_r <= S_ADD_RD;
          end
        end
        S_ADD_RD: state_r <= S_ADD_WR;
        S_ADD_WR: begin
          x_r <= anc_qa_r;
          if (lv_r + LW'(1) == LAST_LV) begin
            count_r <= count_r + CW'(1);
            state_r <= S_DONE;
          end else begin
            lv_r    <= lv_r + LW'(1);
            state_r <= S_ADD_RD;
          end
        end
        // Query: depths and root distances
        S_Q_RD: state_r <= S_Q_DEP;
        S_Q_DEP: begin
          ra_r <= rd_qa_r;
          rb_r <= rd_qb_r;
          lv_r <= '0;
          if (dep_qa_r > dep_qb_r) begin
            x_r    <= a_r;
            y_r    <= b_r;
            diff_r <= dep_qa_r - dep_qb_r;
          end else begin
            x_r    <= b_r;
            y_r    <= a_r;
            diff_r <= dep_qb_r - dep_qa_r;
          end
          state_r <= S_LIFT_RD;
        end
        // Lift the deeper node by the depth difference
        S_LIFT_RD: begin
          if (diff_r[0]) begin
            state_r <= S_LIFT_WR;
          end else begin
            diff_r <= diff_r >> 1;
            if (lv_r == LAST_LV) state_r <= S_CMP;
            else lv_r <= lv_r + LW'(1);
          end
        end
        S_LIFT_WR: begin
          x_r    <= anc_qa_r;
          diff_r <= diff_r >> 1;
          if (lv_r == LAST_LV) begin
            state_r <= S_CMP;
          end else begin
            lv_r    <= lv_r + LW'(1);
            state_r <= S_LIFT_RD;
          end
        end
        S_CMP: begin
          if (x_r == y_r) begin
            state_r <= S_DIST_RD;
          end else begin
            lv_r    <= LAST_LV;
            state_r <= S_DESC_RD;
          end
        end
        // Descend both nodes while their ancestors differ
        S_DESC_RD: state_r <= S_DESC_EV;
        S_DESC_EV: begin
          if (anc_qa_r != anc_qb_r) begin
            x_r <= anc_qa_r;
            y_r <= anc_qb_r;
          end
          if (lv_r == LW'(0)) begin
            state_r <= S_FIN_RD;
          end else begin
            lv_r    <= lv_r - LW'(1);
            state_r <= S_DESC_RD;
          end
        end
        S_FIN_RD: state_r <= S_FIN_EV;
        S_FIN_EV: begin
          x_r     <= anc_qa_r;
          state_r <= S_DIST_RD;
        end
        // Path length from root distances
        S_DIST_RD: state_r <= S_DIST_EV;
        S_DIST_EV: begin
          sa_r    <= ra_r - rd_qa_r;
          sb_r    <= rb_r - rd_qa_r;
          state_r <= S_DIST_SUM;
        end
        S_DIST_SUM: begin
          dist_r  <= OUT_W'(sa_r) + OUT_W'(sb_r);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.distance <= dist_r;
            out_r.status   <= status_r;
            out_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/weighted_tree_lca_distance_unit.sv
`default_nettype none
// Channel  | Ports                          | Moves
// ---------+--------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data    | one command per transfer
// output   | out_valid, out_ready, out_data | one result per command
//
// Start rewrites the root entries, add writes the ancestors of the new
// node, and a query lifts and descends; each is paced by the dependent
// reads of the ancestor memory, one level per read. After reset the root
// entries, one per lift level, are written before the first command is
// taken from the queue. A two-entry queue takes input while the back end
// works, and a result held in the output register stalls only the back end.
module weighted_tree_lca_distance_unit import wtld_pkg::*; #(
  parameter int MAX_NODES   = 65536,
  parameter int LIFT_LEVELS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic      cmd_valid, cmd_pop;
  cmd_item_t cmd_head;

  wtld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_head  (cmd_head)
  );

  wtld_back #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_head  (cmd_head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/weighted_tree_lca_distance_unit_tb.sv
module weighted_tree_lca_distance_unit_tb;
  import wtld_pkg::*;

  localparam int NODE_LIMIT = 65536;
  localparam int LEVELS     = 16;

  // Unused operation code, answered by the block with status OK and zero distance
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Tree distance predictor with a queue of pending results
  class tree_scoreboard;
    int unsigned        count;
    bit [15:0]          depth_of [int unsigned];
    bit [DIST_W-1:0]    rdist_of [int unsigned];
    bit [15:0]          up_of    [int unsigned][LEVELS];
    out_item_t          pending[$];
    int                 errors;

    function void clear_tree();
      count = 1;
      depth_of[0] = 0;
      rdist_of[0] = 0;
      for (int lv = 0; lv < LEVELS; lv++) up_of[0][lv] = 0;
    endfunction

    function int unsigned climb(int unsigned node, int unsigned steps);
      for (int lv = 0; lv < LEVELS; lv++)
        if (steps[lv]) node = up_of[node][lv];
      return node;
    endfunction

    function int unsigned meet(int unsigned a, int unsigned b);
      if (depth_of[a] > depth_of[b]) a = climb(a, depth_of[a] - depth_of[b]);
      else if (depth_of[b] > depth_of[a]) b = climb(b, depth_of[b] - depth_of[a]);
      if (a == b) return a;
      for (int lv = LEVELS - 1; lv >= 0; lv--)
        if (up_of[a][lv] != up_of[b][lv]) begin
          a = up_of[a][lv];
          b = up_of[b][lv];
        end
      return up_of[a][0];
    endfunction

    // Note one accepted input transfer
    function void note_input(in_item_t it);
      out_item_t r;
      int unsigned n, c;
      bit [DIST_W-1:0] da, db;
      r = '0;
      case (it.operation)
        OP_START: clear_tree();
        OP_ADD: begin
          if (count >= NODE_LIMIT) r.status = ST_TABLE_FULL;
          else if (it.node_b >= count) r.status = ST_NO_PARENT;
          else begin
            n = count;
            depth_of[n] = depth_of[it.node_b] + 16'd1;
            rdist_of[n] = rdist_of[it.node_b] + it.weight;
            up_of[n][0] = it.node_b;
            for (int lv = 1; lv < LEVELS; lv++)
              up_of[n][lv] = up_of[up_of[n][lv-1]][lv-1];
            count = n + 1;
          end
        end
        OP_QUERY: begin
          if (it.node_a >= count || it.node_b >= count) r.status = ST_NO_NODE;
          else begin
            c  = meet(it.node_a, it.node_b);
            da = rdist_of[it.node_a] - rdist_of[c];
            db = rdist_of[it.node_b] - rdist_of[c];
            r.distance = {1'b0, da} + {1'b0, db};
          end
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    // Check one accepted result transfer
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result distance=%0d status=%0d",
                 $time, got.distance, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.distance !== want.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time,
                 want.distance, got.distance);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time,
                 want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_data;
  out_item_t out_data;
  int        send_idle, recv_stall;
  tree_scoreboard sb;

  weighted_tree_lca_distance_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("[weighted_tree_lca_distance_unit] ERROR");
    $finish;
  end

  // Result side: random stall, sample on rising edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Drive one input transfer; valid stays up if the next one follows at once
  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic send_op(logic [1:0] op, int a, int b, logic [31:0] w);
    in_item_t it;
    it.operation = op;
    it.node_a = 16'(a);
    it.node_b = 16'(b);
    it.weight = w;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed: adds with present parents and queries of present nodes
  task automatic random_item();
    int unsigned k, cnt;
    logic [95:0] rnd;
    in_item_t it;
    k   = $urandom_range(99);
    cnt = sb.count;
    rnd = {$urandom, $urandom, $urandom};
    it  = rnd[$bits(in_item_t)-1:0];
    if (k < 2) it.operation = OP_START;
    else if (k < 45) begin
      it.operation = OP_ADD;
      if ($urandom_range(9) != 0)
        it.node_b = ($urandom_range(3) == 0) ? 16'(cnt - 1) :
                    16'($urandom_range(cnt - 1));
    end else if (k < 95) begin
      it.operation = OP_QUERY;
      if ($urandom_range(9) != 0) begin
        it.node_a = 16'($urandom_range(cnt - 1));
        it.node_b = 16'($urandom_range(cnt - 1));
      end
    end else it.operation = OP_UNUSED;
    send(it);
  endtask

  initial begin
    sb = new();
    sb.clear_tree();
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
    send_idle = 0; recv_stall = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: extremes, every op, missing-parent and missing-node rejections
    send_op(OP_QUERY, 0, 0, 0);
    send_op(OP_ADD, 0, 1, 32'hFFFF_FFFF);
    send_op(OP_ADD, 0, 0, 32'hFFFF_FFFF);
    send_op(OP_ADD, 0, 1, 32'hFFFF_FFFF);
    send_op(OP_ADD, 0, 0, 0);
    send_op(OP_ADD, 0, 2, 7);
    send_op(OP_QUERY, 2, 3, 0);
    send_op(OP_QUERY, 4, 5, 0);
    send_op(OP_QUERY, 5, 5, 0);
    send_op(OP_QUERY, 0, 65535, 0);
    send_op(OP_QUERY, 65535, 0, 0);
    send_op(OP_ADD, 16'hFFFF, 16'hFFFF, 32'h1234);
    send_op(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(OP_START, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(OP_QUERY, 1, 0, 0);
    // Long chain to exercise high lift levels
    for (int i = 0; i < 40; i++) send_op(OP_ADD, 0, i, $urandom);
    send_op(OP_QUERY, 40, 3, 0);
    send_op(OP_QUERY, 17, 33, 0);

    // Pause until idle
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        3: begin send_idle = 11; recv_stall = 11; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int i = 0; i < 300; i++) random_item();
      if (ph == 2) drain();
    end

    send_idle = 0; recv_stall = 0;
    drain();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[weighted_tree_lca_distance_unit] OK");
    else
      $display("[weighted_tree_lca_distance_unit] ERROR");
    $finish;
  end
endmodule
